@@ rtl/core/dpc_pkg.sv @@
// Shared types, codes and helpers for the dictionary prefix completion block.
// No dependencies.
package dpc_pkg;

  localparam int ENTRY_BYTES     = 10;
  localparam int QUERY_CHARS     = 9;
  localparam int DEF_MAX_ENTRIES = 1024;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] ST_FULL  = 2'd0;
  localparam logic [1:0] ST_AMBIG = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  localparam logic [2:0] REG_MAX_WORD_LEN = 3'd0;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       char_valid;
    logic [7:0] char_value;
    logic       last_res;
  } res_t;

  typedef logic [ENTRY_BYTES-1:0][7:0] entry_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return is_upper(c) ? c + 8'd32 : c;
  endfunction

endpackage

@@ rtl/core/dictionary_prefix_completion.sv @@
// Dictionary prefix completion: table load, query collection, scan and emit.
// Depends on dpc_pkg.
//
//  channel  | signals                       | direction
//  item     | item_valid/item_ready/item    | in, kind/byte_value/last
//  res      | res_valid/res_ready/res       | out, one completion char each
//  config   | psel/penable/pwrite/paddr/... | APB, max_word_len at 0x0
//
// Load bytes and non-final query bytes are taken in S_IDLE and keep item_ready high.
// A final query byte starts a scan: a setup state (S_START), then S_READ and
// S_CMP for each table entry visited (one memory read port, registered read),
// S_PREP to form the result, then one result item per cycle while res_ready is high.
// item_ready is low from the final query byte until the last result item
// is loaded into the output register. Reset empties the table.
module dictionary_prefix_completion
  import dpc_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {S_IDLE, S_START, S_READ, S_CMP, S_PREP, S_EMIT} state_t;

  state_t        state;
  logic [3:0]    max_word_len;
  logic [3:0]    lim;
  logic [3:0]    load_pos;
  logic [CW-1:0] entry_count;
  entry_t        asm_row, asm_next;
  logic [QUERY_CHARS-1:0][7:0] qbuf;
  logic [3:0]    query_length;
  logic [3:0]    qlen, qlen_calc;
  logic [CW-1:0] scan_idx;
  logic          found, multi, match;
  entry_t        first_row, last_row, rd_data;
  logic [3:0]    res_n, n_calc, idx;
  logic          upper, upper_calc;
  logic [1:0]    status;
  entry_t        mem [MAX_ENTRIES];
  logic          acc;

  assign acc        = item_valid && item_ready;
  assign item_ready = (state == S_IDLE);
  assign pready     = 1'b1;
  assign prdata     = {28'd0, max_word_len};
  assign lim = (max_word_len < 4'd9) ? 4'd9 : (max_word_len > 4'd10) ? 4'd10 : max_word_len;

  always_ff @(posedge clk) begin
    if (rst) max_word_len <= 4'd9;
    else if (psel && penable && pwrite && paddr == REG_MAX_WORD_LEN) begin
      max_word_len <= pwdata[3:0];
    end
  end

  // entry assembly: zero-fill at the first byte, drop bytes past the limit
  always_comb begin
    asm_next = (load_pos == 4'd0) ? '0 : asm_row;
    for (int k = 0; k < ENTRY_BYTES; k++) begin
      if (load_pos == 4'(k) && load_pos < lim) asm_next[k] = item.byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && item.kind == KIND_ENTRY && item.last && entry_count < CW'(MAX_ENTRIES)) begin
      mem[entry_count[AW-1:0]] <= asm_next;
    end
    rd_data <= mem[scan_idx[AW-1:0]];
  end

  // leading nonzero query characters
  always_comb begin
    logic run;
    logic [3:0] stored;
    run = 1'b1;
    qlen_calc = '0;
    stored = (query_length < 4'(QUERY_CHARS)) ? query_length : 4'(QUERY_CHARS);
    for (int i = 0; i < QUERY_CHARS; i++) begin
      if (run && 4'(i) < stored && qbuf[i] != 8'd0) qlen_calc = qlen_calc + 4'd1;
      else run = 1'b0;
    end
  end

  // shared compare unit: one table row against the query
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < QUERY_CHARS; i++) begin
      if (4'(i) < qlen && fold(qbuf[i]) != fold(rd_data[i])) match = 1'b0;
    end
  end

  always_comb begin
    logic run;
    logic [3:0] l, lp;
    run = 1'b1;
    l = '0;
    for (int i = 0; i < ENTRY_BYTES; i++) begin
      if (run && 4'(i) < lim && first_row[i] == last_row[i]) l = l + 4'd1;
      else run = 1'b0;
    end
    lp = multi ? l : lim;
    run = 1'b1;
    n_calc = '0;
    upper_calc = 1'b1;
    for (int i = 0; i < ENTRY_BYTES; i++) begin
      if (run && 4'(i) < lp && first_row[i] != 8'd0) begin
        n_calc = n_calc + 4'd1;
        if (!is_upper(first_row[i])) upper_calc = 1'b0;
      end else begin
        run = 1'b0;
      end
    end
    if (!found) n_calc = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      load_pos     <= '0;
      query_length <= '0;
      res_valid    <= 1'b0;
      found        <= 1'b0;
      multi        <= 1'b0;
    end else begin
      // in S_EMIT the output register is reloaded below instead
      if (res_valid && res_ready && state != S_EMIT) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            case (item.kind)
              KIND_CLEAR: begin
                entry_count <= '0;
                load_pos    <= '0;
              end
              KIND_ENTRY: begin
                asm_row <= asm_next;
                if (item.last) begin
                  load_pos <= '0;
                  if (entry_count < CW'(MAX_ENTRIES)) entry_count <= entry_count + 1'b1;
                end else if (load_pos != 4'd15) begin
                  load_pos <= load_pos + 4'd1;
                end
              end
              KIND_QUERY: begin
                if (query_length < 4'(QUERY_CHARS)) qbuf[query_length] <= item.byte_value;
                if (query_length != 4'd15) query_length <= query_length + 4'd1;
                if (item.last) state <= S_START;
              end
              default: ;
            endcase
          end
        end
        S_START: begin
          qlen         <= qlen_calc;
          query_length <= '0;
          found        <= 1'b0;
          multi        <= 1'b0;
          scan_idx     <= '0;
          if (qlen_calc < 4'd2 || entry_count == '0) state <= S_PREP;
          else state <= S_READ;
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (match) begin
            if (!found) first_row <= rd_data;
            else multi <= 1'b1;
            found    <= 1'b1;
            last_row <= rd_data;
          end
          if (!match && found) begin
            state <= S_PREP;
          end else if (scan_idx + 1'b1 < entry_count) begin
            scan_idx <= scan_idx + 1'b1;
            state    <= S_READ;
          end else begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          res_n  <= n_calc;
          upper  <= upper_calc;
          status <= !found ? ST_NONE : (multi ? ST_AMBIG : ST_FULL);
          idx    <= '0;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_valid || res_ready) begin
            res_valid      <= 1'b1;
            res.status     <= status;
            res.char_valid <= (res_n != 4'd0);
            res.char_value <= (res_n == 4'd0) ? 8'd0 :
                              (upper ? fold(first_row[idx]) : first_row[idx]);
            res.last_res   <= (res_n == 4'd0) || (idx + 4'd1 == res_n);
            idx            <= idx + 4'd1;
            if (res_n == 4'd0 || idx + 4'd1 == res_n) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(MAX_ENTRIES)) else $error("entry count past capacity");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.char_valid |-> res.last_res) else $error("empty result not final");

  a_query_stalls: assert property (@(posedge clk) disable iff (rst)
    acc && item.kind == KIND_QUERY && item.last |=> !item_ready)
    else $error("final query byte did not start a scan");

  a_none_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_NONE |-> !res.char_valid)
    else $error("not found carries a character");

endmodule
